[rtl/core/kea_pkg.sv]
`default_nettype none

package kea_pkg;

   // Angle word: signed, with four integer bits.
   localparam int ANGLE_WIDTH = 32;
   localparam int FRAC        = ANGLE_WIDTH - 4;
   // Residual and its magnitude, with headroom for E - e*sin(E) - M.
   localparam int DELTA_WIDTH = ANGLE_WIDTH + 2;
   // Saturated quotient, at most 2^ANGLE_WIDTH.
   localparam int QUOT_WIDTH  = ANGLE_WIDTH + 1;
   // Denominator 2^46 - e*cos(E) lies in (0, 2^47].
   localparam int DEN_WIDTH   = 48;
   localparam int DEN_FRAC    = 46;

   localparam int CORDIC_STEPS = 31;
   localparam int STEP_WIDTH   = 5;
   localparam int XY_WIDTH     = 34;
   localparam int Z_WIDTH      = 36;
   localparam int PROD_WIDTH   = 51;

   localparam logic signed [Z_WIDTH-1:0]  PI_Q30      = 36'sd3373259426;
   localparam logic signed [Z_WIDTH-1:0]  TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [Z_WIDTH-1:0]  HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [XY_WIDTH-1:0] GAIN_Q30    = 34'sd652032874;

   localparam logic [28:0] TOLERANCE_RESET  = 29'd2684;
   localparam logic [7:0]  PASS_LIMIT_RESET = 8'd100;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 29;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE  = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PASS_LIMIT = 8'd1;

   typedef struct packed {
      logic signed [ANGLE_WIDTH-1:0] mean_anomaly;
      logic [15:0]                   eccentricity;
   } req_payload_type;

   typedef struct packed {
      logic signed [ANGLE_WIDTH-1:0] eccentric_anomaly;
      logic [8:0]                    passes_used;
      logic                          converged;
   } rsp_payload_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Arctangent of 2^-i in Q2.30.
   function automatic logic [Z_WIDTH-1:0] atan_q30(input logic [STEP_WIDTH-1:0] i);
      logic [Z_WIDTH-1:0] v;
      case (i)
         5'd0:  v = 36'd843314856;
         5'd1:  v = 36'd497837829;
         5'd2:  v = 36'd263043836;
         5'd3:  v = 36'd133525158;
         5'd4:  v = 36'd67021686;
         5'd5:  v = 36'd33543515;
         5'd6:  v = 36'd16775850;
         5'd7:  v = 36'd8388437;
         5'd8:  v = 36'd4194282;
         5'd9:  v = 36'd2097149;
         5'd10: v = 36'd1048575;
         5'd11: v = 36'd524287;
         5'd12: v = 36'd262143;
         5'd13: v = 36'd131071;
         5'd14: v = 36'd65535;
         5'd15: v = 36'd32767;
         5'd16: v = 36'd16383;
         5'd17: v = 36'd8191;
         5'd18: v = 36'd4095;
         5'd19: v = 36'd2047;
         5'd20: v = 36'd1023;
         5'd21: v = 36'd511;
         5'd22: v = 36'd255;
         5'd23: v = 36'd127;
         5'd24: v = 36'd63;
         5'd25: v = 36'd31;
         5'd26: v = 36'd15;
         5'd27: v = 36'd8;
         5'd28: v = 36'd4;
         5'd29: v = 36'd2;
         5'd30: v = 36'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

[rtl/core/kea_div.sv]
`default_nettype none

module kea_div
   import kea_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [DELTA_WIDTH-1:0] num,
   input  wire logic [DEN_WIDTH-1:0]   den,
   output div_status_type              status,
   output logic [QUOT_WIDTH-1:0]       quotient
);

   // One restoring step per cycle over the numerator bits and the
   // fraction bits that follow them.
   localparam int STEPS   = DELTA_WIDTH + DEN_FRAC;
   localparam int CNT_W   = $clog2(STEPS + 1);
   localparam int QW      = ANGLE_WIDTH + 2;
   localparam int RW      = DEN_WIDTH + 1;
   localparam logic [QW-1:0] CAP = QW'(1) << ANGLE_WIDTH;

   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DELTA_WIDTH-1:0] nsr_ff, nsr_in;
   logic [RW-1:0]          rem_ff, rem_in;
   logic [QW-1:0]          q_ff, q_in;
   logic [DEN_WIDTH-1:0]   den_ff, den_in;
   logic [RW-1:0]          rem_sh;
   logic [QW-1:0]          q_sh;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      nsr_in  = nsr_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff[RW-2:0], nsr_ff[DELTA_WIDTH-1]};
      q_sh    = (q_ff >= CAP) ? CAP : (q_ff << 1);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS);
         nsr_in  = num;
         rem_in  = '0;
         q_in    = '0;
         den_in  = den;
      end else if (busy_ff) begin
         nsr_in = nsr_ff << 1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            if (q_sh < CAP) begin
               q_sh = q_sh | QW'(1);
            end
         end else begin
            rem_in = rem_sh;
         end
         q_in   = (q_sh > CAP) ? CAP : q_sh;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      nsr_ff <= nsr_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff[QUOT_WIDTH-1:0];

endmodule

`default_nettype wire

[rtl/core/kepler_eccentric_anomaly.sv]
`default_nettype none

// Kepler equation solver: for each transfer on the req_ channel (mean
// anomaly M and eccentricity e) it returns one transfer on the rsp_
// channel holding the eccentric anomaly E with E - e*sin(E) = M, the
// number of Newton passes used and a converged flag.
// The block takes one item at a time; req_ready is low from the
// accepted transfer until the result has been loaded into the output
// register. Each Newton pass runs a 31-step CORDIC for sine and cosine
// and a first use of one shared 17x34 multiplier for e*sin(E). A pass
// that has not converged makes a second use of the multiplier, for
// e*cos(E), and runs a restoring divider that retires one quotient bit
// per cycle and takes most of the pass; a converging pass skips the
// second multiply and the divider.
// The result sits in an output register: a stall on rsp_ready holds it
// there, and the solver finishes the next item and then waits only if
// the previous result has still not been taken.
// The csr_ channel is always ready; index 0 writes the tolerance and
// index 1 the pass limit, other indices are ignored. Synchronous reset
// restores both to their defaults and empties the block.

module kepler_eccentric_anomaly
   import kea_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire req_payload_type            req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output rsp_payload_type                 rsp_payload,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int AW  = ANGLE_WIDTH;
   localparam int DW  = DELTA_WIDTH;
   localparam int ZSL = (FRAC < 30) ? 30 - FRAC : 0;
   localparam int ZSR = (FRAC >= 30) ? FRAC - 30 : 0;
   localparam int TSL = (FRAC >= 28) ? FRAC - 28 : 0;
   localparam int TSR = (FRAC < 28) ? 28 - FRAC : 0;
   localparam int PSR = DEN_FRAC - FRAC;
   localparam int EW  = AW + 3;

   localparam logic signed [AW-1:0] E_MAX = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] E_MIN = {1'b1, {(AW-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TEST,
      ST_REDUCE,
      ST_ROTATE,
      ST_MUL_S,
      ST_DELTA,
      ST_MUL_C,
      ST_DEN,
      ST_DIV_GO,
      ST_DIV,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type                    state_ff;
   logic [28:0]                  tolerance_ff;
   logic [7:0]                   pass_limit_ff;
   logic signed [AW-1:0]         m_ff;
   logic [15:0]                  ecc_ff;
   logic signed [AW-1:0]         e_ff;
   logic [8:0]                   iter_ff;
   logic                         conv_ff;
   logic signed [Z_WIDTH-1:0]    z_ff;
   logic signed [XY_WIDTH-1:0]   x_ff, y_ff;
   logic                         neg_ff;
   logic [STEP_WIDTH-1:0]        step_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic signed [DW-1:0]         delta_ff;
   logic [DEN_WIDTH-1:0]         den_ff;
   logic                         rsp_valid_ff;
   rsp_payload_type              rsp_ff;

   logic signed [63:0]           z_wide;
   logic signed [Z_WIDTH-1:0]    z_init;
   logic signed [DW-1:0]         tol;
   logic signed [63:0]           tol_wide;
   logic signed [XY_WIDTH-1:0]   sin_v, cos_v, mul_b;
   logic signed [PROD_WIDTH-1:0] mul_p;
   logic signed [PROD_WIDTH-1:0] term_wide;
   logic signed [DW-1:0]         delta_new;
   logic [DW-1:0]                abs_delta;
   logic signed [DEN_WIDTH:0]    den_wide;
   logic signed [XY_WIDTH-1:0]   x_sh, y_sh;
   logic signed [EW-1:0]         e_wide;
   logic signed [AW-1:0]         e_sat;
   logic                         div_start;
   div_status_type               div_status;
   logic [QUOT_WIDTH-1:0]        div_q;
   logic                         rsp_load;

   // Angle rescaled to Q2.30 for the CORDIC, and tolerance to FRAC bits.
   assign z_wide   = (64'(e_ff) <<< ZSL) >>> ZSR;
   assign z_init   = z_wide[Z_WIDTH-1:0];
   assign tol_wide = (64'({35'd0, tolerance_ff}) << TSL) >> TSR;
   assign tol      = tol_wide[DW-1:0];

   // Folded results of the rotation.
   assign sin_v = neg_ff ? -y_ff : y_ff;
   assign cos_v = neg_ff ? -x_ff : x_ff;

   // The one multiplier: eccentricity times sine, later times cosine.
   assign mul_b = (state_ff == ST_MUL_S) ? sin_v : cos_v;
   assign mul_p = PROD_WIDTH'($signed({1'b0, ecc_ff}) * mul_b);

   assign term_wide = prod_ff >>> PSR;
   assign delta_new = DW'(e_ff) - term_wide[DW-1:0] - DW'(m_ff);
   assign abs_delta = delta_ff[DW-1] ? DW'(-delta_ff) : DW'(delta_ff);
   assign den_wide  = (49'sd1 <<< DEN_FRAC) - (DEN_WIDTH+1)'(prod_ff);

   assign x_sh = x_ff >>> step_ff;
   assign y_sh = y_ff >>> step_ff;

   // Newton update with saturation to the angle range.
   always_comb begin
      if (delta_ff[DW-1]) begin
         e_wide = EW'(e_ff) + $signed({2'b00, div_q});
      end else begin
         e_wide = EW'(e_ff) - $signed({2'b00, div_q});
      end
      if (e_wide > EW'(E_MAX)) begin
         e_sat = E_MAX;
      end else if (e_wide < EW'(E_MIN)) begin
         e_sat = E_MIN;
      end else begin
         e_sat = e_wide[AW-1:0];
      end
   end

   assign div_start = (state_ff == ST_DIV_GO);

   // The finished result moves to the output register once it is free.
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   kea_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (abs_delta),
      .den      (den_ff),
      .status   (div_status),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tolerance_ff  <= TOLERANCE_RESET;
         pass_limit_ff <= PASS_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_TOLERANCE:  tolerance_ff  <= csr_data;
               CSR_PASS_LIMIT: pass_limit_ff <= csr_data[7:0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  m_ff     <= req_payload.mean_anomaly;
                  ecc_ff   <= req_payload.eccentricity;
                  e_ff     <= req_payload.mean_anomaly;
                  iter_ff  <= '0;
                  conv_ff  <= 1'b0;
                  state_ff <= ST_TEST;
               end
            end
            ST_TEST: begin
               // The count is tested before it is bumped.
               iter_ff <= iter_ff + 9'd1;
               if (iter_ff > {1'b0, pass_limit_ff}) begin
                  state_ff <= ST_FINISH;
               end else begin
                  z_ff     <= z_init;
                  state_ff <= ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               if (z_ff > PI_Q30) begin
                  z_ff <= z_ff - TWO_PI_Q30;
               end else if (z_ff < -PI_Q30) begin
                  z_ff <= z_ff + TWO_PI_Q30;
               end else begin
                  if (z_ff > HALF_PI_Q30) begin
                     z_ff   <= z_ff - PI_Q30;
                     neg_ff <= 1'b1;
                  end else if (z_ff < -HALF_PI_Q30) begin
                     z_ff   <= z_ff + PI_Q30;
                     neg_ff <= 1'b1;
                  end else begin
                     neg_ff <= 1'b0;
                  end
                  x_ff     <= GAIN_Q30;
                  y_ff     <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_ROTATE;
               end
            end
            ST_ROTATE: begin
               if (z_ff >= 0) begin
                  x_ff <= x_ff - y_sh;
                  y_ff <= y_ff + x_sh;
                  z_ff <= z_ff - $signed(atan_q30(step_ff));
               end else begin
                  x_ff <= x_ff + y_sh;
                  y_ff <= y_ff - x_sh;
                  z_ff <= z_ff + $signed(atan_q30(step_ff));
               end
               step_ff <= step_ff + STEP_WIDTH'(1);
               if (step_ff == STEP_WIDTH'(CORDIC_STEPS - 1)) begin
                  state_ff <= ST_MUL_S;
               end
            end
            ST_MUL_S: begin
               prod_ff  <= mul_p;
               state_ff <= ST_DELTA;
            end
            ST_DELTA: begin
               delta_ff <= delta_new;
               state_ff <= ST_MUL_C;
            end
            ST_MUL_C: begin
               if ($signed(abs_delta) < tol) begin
                  conv_ff  <= 1'b1;
                  state_ff <= ST_FINISH;
               end else begin
                  prod_ff  <= mul_p;
                  state_ff <= ST_DEN;
               end
            end
            ST_DEN: begin
               // Cannot go non-positive for e below one; clamp anyway.
               if (den_wide < 1) begin
                  den_ff <= DEN_WIDTH'(1);
               end else begin
                  den_ff <= den_wide[DEN_WIDTH-1:0];
               end
               state_ff <= ST_DIV_GO;
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_status.done) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               e_ff     <= e_sat;
               state_ff <= ST_TEST;
            end
            ST_FINISH: begin
               if (rsp_load) begin
                  rsp_ff.eccentric_anomaly <= e_ff;
                  rsp_ff.passes_used       <= iter_ff;
                  rsp_ff.converged         <= conv_ff;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A new item is taken only once the previous one is out of the solver.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while solver busy");

   // The divider runs only while the sequencer waits on it.
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == ST_DIV)
      else $error("divider busy outside its state");

   // A result always reports at least one pass.
   a_passes_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.passes_used != 9'd0)
      else $error("result with zero passes");

   // A search stopped by the limit used exactly limit plus two counts.
   a_limit_count: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && !rsp_payload.converged
         |-> rsp_payload.passes_used == {1'b0, pass_limit_ff} + 9'd2)
      else $error("pass count wrong at limit");

endmodule

`default_nettype wire
